[sv/assert_macros.svh]
// Assertion macros shared by the checker files.
// Depends on nothing; guarded against double inclusion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/jsu_pkg.sv]
// Shared types, codes and helpers for the JSON string unescaper.
// Used by every module of the block; depends on nothing.
package jsu_pkg;

  typedef enum logic [2:0] {
    KIND_BYTE     = 3'd0,
    KIND_CLOSED   = 3'd1,
    KIND_NO_CLOSE = 3'd2,
    KIND_BAD_ESC  = 3'd3,
    KIND_BAD_HEX  = 3'd4,
    KIND_BAD_SURR = 3'd5,
    KIND_CTRL     = 3'd6,
    KIND_NO_OPEN  = 3'd7
  } kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_BODY    = 3'd1,
    MODE_ESC     = 3'd2,
    MODE_HEX1    = 3'd3,
    MODE_WANT_BS = 3'd4,
    MODE_WANT_U  = 3'd5,
    MODE_HEX2    = 3'd6
  } mode_t;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UF     = 8'h46;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LF     = 8'h66;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [7:0] BYTE_BS  = 8'h08;
  localparam logic [7:0] BYTE_FF  = 8'h0C;
  localparam logic [7:0] BYTE_LF  = 8'h0A;
  localparam logic [7:0] BYTE_CR  = 8'h0D;
  localparam logic [7:0] BYTE_TAB = 8'h09;

  // Top six bits of a UTF-16 unit: high surrogate D800..DBFF, low DC00..DFFF.
  localparam logic [5:0] SURR_HI_TAG = 6'b110110;
  localparam logic [5:0] SURR_LO_TAG = 6'b110111;
  localparam logic [20:0] SUPP_BASE  = 21'h10000;
  localparam logic [15:0] LEN_MAX    = 16'hFFFF;
  localparam logic [1:0]  HEX_LAST   = 2'd3;

  localparam int RES_MAX = 4;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [15:0] length;
  } res_t;

  typedef struct packed {
    logic [2:0]         n;
    res_t [RES_MAX-1:0] res;
  } dec_out_t;

  typedef struct packed {
    logic [2:0]       n;
    logic [3:0][7:0]  bytes;
  } utf8_t;

  // Hex digit value, MSB set when the byte is a valid digit.
  function automatic logic [4:0] hex_of(input logic [7:0] b);
    logic [4:0] r;
    r = '0;
    if (b >= CH_0 && b <= CH_9) begin
      r = {1'b1, 4'(b - CH_0)};
    end else if (b >= CH_UA && b <= CH_UF) begin
      r = {1'b1, 4'(b - CH_UA + 8'd10)};
    end else if (b >= CH_LA && b <= CH_LF) begin
      r = {1'b1, 4'(b - CH_LA + 8'd10)};
    end
    return r;
  endfunction

endpackage

[sv/jsu_utf8.sv]
// UTF-8 encoder: one code point in, one to four bytes out, first byte in lane 0.
// Depends on jsu_pkg.
module jsu_utf8 (
  input  logic [20:0]   cp,
  output jsu_pkg::utf8_t enc
);

  always_comb begin
    enc = '0;
    if (cp < 21'h80) begin
      enc.n        = 3'd1;
      enc.bytes[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      enc.n        = 3'd2;
      enc.bytes[0] = {3'b110, cp[10:6]};
      enc.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp < jsu_pkg::SUPP_BASE) begin
      enc.n        = 3'd3;
      enc.bytes[0] = {4'b1110, cp[15:12]};
      enc.bytes[1] = {2'b10, cp[11:6]};
      enc.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      enc.n        = 3'd4;
      enc.bytes[0] = {5'b11110, cp[20:18]};
      enc.bytes[1] = {2'b10, cp[17:12]};
      enc.bytes[2] = {2'b10, cp[11:6]};
      enc.bytes[3] = {2'b10, cp[5:0]};
    end
  end

endmodule

[sv/jsu_decode.sv]
// Escape decoder: parse state and the results of one byte.
// Depends on jsu_pkg and jsu_utf8.
module jsu_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [7:0]        in_byte,
  output jsu_pkg::dec_out_t dec
);

  jsu_pkg::mode_t mode_r, mode_nxt;
  logic [15:0] hex_value_r, hex_value_nxt;
  logic [1:0]  hex_seen_r, hex_seen_nxt;
  logic [9:0]  high_half_r, high_half_nxt;
  logic [15:0] byte_count_r, byte_count_nxt;

  logic [4:0]  hex;
  logic        hex_ok;
  logic [15:0] u;
  logic        hex_done;
  logic        esc_ok;
  logic [7:0]  esc_byte;
  logic [20:0] cp;
  logic [2:0]  nbytes;
  logic [16:0] count_sum;
  jsu_pkg::utf8_t enc;

  assign hex      = jsu_pkg::hex_of(in_byte);
  assign hex_ok   = hex[4];
  assign u        = {hex_value_r[11:0], hex[3:0]};
  assign hex_done = (hex_seen_r == jsu_pkg::HEX_LAST);
  assign cp       = (mode_r == jsu_pkg::MODE_HEX2) ?
                    (21'({high_half_r, u[9:0]}) + jsu_pkg::SUPP_BASE) : 21'(u);

  jsu_utf8 u_utf8 (
    .cp  (cp),
    .enc (enc)
  );

  // Single-byte escapes.
  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = in_byte;
    unique case (in_byte)
      jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: esc_byte = in_byte;
      jsu_pkg::CH_B: esc_byte = jsu_pkg::BYTE_BS;
      jsu_pkg::CH_F: esc_byte = jsu_pkg::BYTE_FF;
      jsu_pkg::CH_N: esc_byte = jsu_pkg::BYTE_LF;
      jsu_pkg::CH_R: esc_byte = jsu_pkg::BYTE_CR;
      jsu_pkg::CH_T: esc_byte = jsu_pkg::BYTE_TAB;
      default: esc_ok = 1'b0;
    endcase
  end

  // Next state.
  always_comb begin
    mode_nxt      = mode_r;
    hex_value_nxt = hex_value_r;
    hex_seen_nxt  = hex_seen_r;
    high_half_nxt = high_half_r;
    unique case (mode_r)
      jsu_pkg::MODE_IDLE: begin
        if (in_byte == jsu_pkg::CH_QUOTE) mode_nxt = jsu_pkg::MODE_BODY;
      end
      jsu_pkg::MODE_BODY: begin
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          mode_nxt = jsu_pkg::MODE_IDLE;
        end else if (in_byte == jsu_pkg::CH_BSLASH) begin
          mode_nxt = jsu_pkg::MODE_ESC;
        end else if (in_byte < jsu_pkg::CTRL_LIMIT) begin
          mode_nxt = jsu_pkg::MODE_IDLE;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (in_byte == jsu_pkg::CH_U) begin
          mode_nxt      = jsu_pkg::MODE_HEX1;
          hex_value_nxt = '0;
          hex_seen_nxt  = '0;
        end else if (esc_ok) begin
          mode_nxt = jsu_pkg::MODE_BODY;
        end else begin
          mode_nxt = jsu_pkg::MODE_IDLE;
        end
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (!hex_ok) begin
          mode_nxt = jsu_pkg::MODE_IDLE;
        end else if (!hex_done) begin
          hex_value_nxt = u;
          hex_seen_nxt  = hex_seen_r + 2'd1;
        end else begin
          hex_value_nxt = u;
          hex_seen_nxt  = '0;
          if (mode_r == jsu_pkg::MODE_HEX1) begin
            if (u[15:10] == jsu_pkg::SURR_HI_TAG) begin
              high_half_nxt = u[9:0];
              mode_nxt      = jsu_pkg::MODE_WANT_BS;
            end else begin
              mode_nxt = jsu_pkg::MODE_BODY;
            end
          end else if (u[15:10] == jsu_pkg::SURR_LO_TAG) begin
            mode_nxt = jsu_pkg::MODE_BODY;
          end else begin
            mode_nxt = jsu_pkg::MODE_IDLE;
          end
        end
      end
      jsu_pkg::MODE_WANT_BS: begin
        mode_nxt = (in_byte == jsu_pkg::CH_BSLASH) ? jsu_pkg::MODE_WANT_U
                                                   : jsu_pkg::MODE_IDLE;
      end
      jsu_pkg::MODE_WANT_U: begin
        if (in_byte == jsu_pkg::CH_U) begin
          mode_nxt      = jsu_pkg::MODE_HEX2;
          hex_value_nxt = '0;
          hex_seen_nxt  = '0;
        end else begin
          mode_nxt = jsu_pkg::MODE_IDLE;
        end
      end
      default: mode_nxt = jsu_pkg::MODE_IDLE;
    endcase

    // Saturating decoded length; an opening quote starts a new count.
    count_sum = {1'b0, byte_count_r} + 17'(nbytes);
    if (mode_r == jsu_pkg::MODE_IDLE && in_byte == jsu_pkg::CH_QUOTE) begin
      byte_count_nxt = '0;
    end else begin
      byte_count_nxt = count_sum[16] ? jsu_pkg::LEN_MAX : count_sum[15:0];
    end
  end

  // Results of this byte.
  always_comb begin
    dec    = '0;
    nbytes = '0;
    unique case (mode_r)
      jsu_pkg::MODE_IDLE: begin
        if (in_byte != jsu_pkg::CH_QUOTE) begin
          dec.n           = 3'd1;
          dec.res[0].kind = jsu_pkg::KIND_NO_OPEN;
        end
      end
      jsu_pkg::MODE_BODY: begin
        if (in_byte == jsu_pkg::CH_QUOTE) begin
          dec.n             = 3'd1;
          dec.res[0].kind   = jsu_pkg::KIND_CLOSED;
          dec.res[0].length = byte_count_r;
        end else if (in_byte == jsu_pkg::CH_BSLASH) begin
          dec.n = 3'd0;
        end else if (in_byte == jsu_pkg::CH_NUL) begin
          dec.n           = 3'd1;
          dec.res[0].kind = jsu_pkg::KIND_NO_CLOSE;
        end else if (in_byte < jsu_pkg::CTRL_LIMIT) begin
          dec.n           = 3'd1;
          dec.res[0].kind = jsu_pkg::KIND_CTRL;
        end else begin
          dec.n           = 3'd1;
          nbytes          = 3'd1;
          dec.res[0].kind = jsu_pkg::KIND_BYTE;
          dec.res[0].data = in_byte;
        end
      end
      jsu_pkg::MODE_ESC: begin
        if (in_byte == jsu_pkg::CH_U) begin
          dec.n = 3'd0;
        end else if (esc_ok) begin
          dec.n           = 3'd1;
          nbytes          = 3'd1;
          dec.res[0].kind = jsu_pkg::KIND_BYTE;
          dec.res[0].data = esc_byte;
        end else begin
          dec.n           = 3'd1;
          dec.res[0].kind = jsu_pkg::KIND_BAD_ESC;
        end
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        if (!hex_ok) begin
          dec.n           = 3'd1;
          dec.res[0].kind = jsu_pkg::KIND_BAD_HEX;
        end else if (hex_done) begin
          if (mode_r == jsu_pkg::MODE_HEX2 && u[15:10] != jsu_pkg::SURR_LO_TAG) begin
            dec.n           = 3'd1;
            dec.res[0].kind = jsu_pkg::KIND_BAD_SURR;
          end else if (mode_r == jsu_pkg::MODE_HEX2 ||
                       u[15:10] != jsu_pkg::SURR_HI_TAG) begin
            dec.n  = enc.n;
            nbytes = enc.n;
            for (int i = 0; i < jsu_pkg::RES_MAX; i++) begin
              dec.res[i].kind = jsu_pkg::KIND_BYTE;
              dec.res[i].data = enc.bytes[i];
            end
          end
        end
      end
      jsu_pkg::MODE_WANT_BS: begin
        if (in_byte != jsu_pkg::CH_BSLASH) begin
          dec.n           = 3'd1;
          dec.res[0].kind = jsu_pkg::KIND_BAD_SURR;
        end
      end
      jsu_pkg::MODE_WANT_U: begin
        if (in_byte != jsu_pkg::CH_U) begin
          dec.n           = 3'd1;
          dec.res[0].kind = jsu_pkg::KIND_BAD_SURR;
        end
      end
      default: dec.n = 3'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= jsu_pkg::MODE_IDLE;
      hex_value_r  <= '0;
      hex_seen_r   <= '0;
      high_half_r  <= '0;
      byte_count_r <= '0;
    end else if (adv) begin
      mode_r       <= mode_nxt;
      hex_value_r  <= hex_value_nxt;
      hex_seen_r   <= hex_seen_nxt;
      high_half_r  <= high_half_nxt;
      byte_count_r <= byte_count_nxt;
    end
  end

endmodule

[sv/jsu_outbuf.sv]
// Result register: holds up to four results of one byte and sends them as beats.
// Depends on jsu_pkg.
module jsu_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  jsu_pkg::dec_out_t dec,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [23:0]       out_tdata,   // out_byte[7:0], out_length[23:8]
  output logic [2:0]        out_tuser,   // kind[2:0]
  output logic              out_tlast
);

  jsu_pkg::res_t [jsu_pkg::RES_MAX-1:0] ent_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       fire;
  jsu_pkg::res_t cur;

  assign cur        = ent_r[idx_r];
  assign out_tvalid = (cnt_r != 3'd0);
  assign out_tdata  = {cur.length, cur.data};
  assign out_tuser  = cur.kind;
  assign out_tlast  = (cnt_r == 3'd1);
  assign fire       = out_tvalid && out_tready;
  // Room for the next byte's results once the final beat leaves.
  assign free       = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_tready);

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = dec.n;
      idx_nxt = '0;
    end else if (fire) begin
      cnt_nxt = cnt_r - 3'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) ent_r <= dec.res;
  end

endmodule

[sv/json_string_unescape.sv]
// Top level of the JSON string unescaper: input register, decoder, result register.
// Depends on jsu_pkg, jsu_decode, jsu_utf8 and jsu_outbuf.
//
// Feed the bytes of a quoted JSON string, opening quote first, one beat per byte.
// Each byte yields zero to four result beats: a decoded UTF-8 byte, a close with
// the decoded length, or an error, and tlast marks the final beat of that byte.
// The input takes one byte per cycle while out_tready is high and each byte gives
// at most one result; a \u escape that expands to two, three or four UTF-8 bytes
// holds the input until its final beat leaves the result register, which sends
// one beat per cycle while out_tready is high; input and results are registered.
// After a close or any error the block is idle and waits for a quote.
module json_string_unescape (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // in_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // out_byte[7:0], out_length[23:8]
  output logic [2:0]  out_tuser,   // kind[2:0]
  output logic        out_tlast
);

  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       free;
  logic       load;
  jsu_pkg::dec_out_t dec;

  assign load      = in_valid_r && free;
  assign in_tready = !in_valid_r || load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) in_byte_r <= in_tdata;
  end

  jsu_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (load),
    .in_byte (in_byte_r),
    .dec     (dec)
  );

  jsu_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .dec        (dec),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

[sv/jsu_checker.sv]
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and assert_macros.svh.
`include "assert_macros.svh"

module jsu_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);

  // Hold a stalled beat.
  `ASSERT_CLK(a_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "result beat changed while stalled")

  // A close or an error is always the final beat of its byte.
  `ASSERT_CLK(a_end_last, clk, rst_n, out_tvalid && out_tuser != jsu_pkg::KIND_BYTE |-> out_tlast, "close or error beat without tlast")

  // Only byte beats carry a byte; only a close carries a length.
  `ASSERT_CLK(a_byte_zero, clk, rst_n, out_tvalid && out_tuser != jsu_pkg::KIND_BYTE |-> out_tdata[7:0] == 8'd0, "non-byte beat carries a byte")
  `ASSERT_CLK(a_len_zero, clk, rst_n, out_tvalid && out_tuser != jsu_pkg::KIND_CLOSED |-> out_tdata[23:8] == 16'd0, "non-close beat carries a length")

  // Drop all results on reset and come out ready for input.
  `ASSERT_ALWAYS(a_reset, clk, !rst_n |=> !out_tvalid && in_tready, "busy right after reset")

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (.*);

[test/json_string_unescape_checker.sv]
`timescale 1ns / 1ps
// Stream checker for the JSON string unescaper: predicts the result beats of every
// accepted text byte and compares them field by field. Depends on jsu_pkg.
module json_string_unescape_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,    // in_byte[7:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,   // out_byte[7:0], out_length[23:8]
  input  logic [2:0]  out_tuser,   // kind[2:0]
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending
);

  typedef struct {
    jsu_pkg::kind_t kind;
    logic [7:0]     data;
    logic [15:0]    length;
    logic           last;
  } beat_t;

  beat_t decoded[$];     // predicted result beats, oldest first
  beat_t step_beats[$];  // beats caused by the byte being decoded
  beat_t want;

  jsu_pkg::mode_t mode;
  logic [15:0]    unit_acc;
  logic [1:0]     digits;
  logic [9:0]     high_bits;
  logic [15:0]    char_count;

  task automatic add_beat(input jsu_pkg::kind_t k, input logic [7:0] d,
                          input logic [15:0] len);
    beat_t x;
    x.kind = k;
    x.data = d;
    x.length = len;
    x.last = 1'b0;
    step_beats = {step_beats, x};
  endtask

  task automatic add_char(input logic [7:0] d);
    add_beat(jsu_pkg::KIND_BYTE, d, 16'd0);
    if (char_count != jsu_pkg::LEN_MAX) char_count = char_count + 16'd1;
  endtask

  task automatic abort(input jsu_pkg::kind_t k);
    add_beat(k, 8'd0, 16'd0);
    mode = jsu_pkg::MODE_IDLE;
  endtask

  task automatic add_utf8(input logic [20:0] cp);
    if (cp < 21'h80) begin
      add_char(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_char({3'b110, cp[10:6]});
      add_char({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_char({4'b1110, cp[15:12]});
      add_char({2'b10, cp[11:6]});
      add_char({2'b10, cp[5:0]});
    end else begin
      add_char({5'b11110, cp[20:18]});
      add_char({2'b10, cp[17:12]});
      add_char({2'b10, cp[11:6]});
      add_char({2'b10, cp[5:0]});
    end
  endtask

  task automatic unescape_byte(input logic [7:0] b);
    logic [4:0]  nib;   // bit 4 set for a hex digit
    logic [15:0] word;
    step_beats.delete();
    case (mode)
      jsu_pkg::MODE_IDLE: begin
        if (b == jsu_pkg::CH_QUOTE) begin
          mode = jsu_pkg::MODE_BODY;
          char_count = 16'd0;
        end else begin
          abort(jsu_pkg::KIND_NO_OPEN);
        end
      end
      jsu_pkg::MODE_BODY: begin
        if (b == jsu_pkg::CH_QUOTE) begin
          add_beat(jsu_pkg::KIND_CLOSED, 8'd0, char_count);
          mode = jsu_pkg::MODE_IDLE;
        end else if (b == jsu_pkg::CH_BSLASH) begin
          mode = jsu_pkg::MODE_ESC;
        end else if (b == jsu_pkg::CH_NUL) begin
          abort(jsu_pkg::KIND_NO_CLOSE);
        end else if (b < jsu_pkg::CTRL_LIMIT) begin
          abort(jsu_pkg::KIND_CTRL);
        end else begin
          add_char(b);
        end
      end
      jsu_pkg::MODE_ESC: begin
        mode = jsu_pkg::MODE_BODY;
        case (b)
          jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH: add_char(b);
          jsu_pkg::CH_B: add_char(jsu_pkg::BYTE_BS);
          jsu_pkg::CH_F: add_char(jsu_pkg::BYTE_FF);
          jsu_pkg::CH_N: add_char(jsu_pkg::BYTE_LF);
          jsu_pkg::CH_R: add_char(jsu_pkg::BYTE_CR);
          jsu_pkg::CH_T: add_char(jsu_pkg::BYTE_TAB);
          jsu_pkg::CH_U: begin
            mode = jsu_pkg::MODE_HEX1;
            unit_acc = 16'd0;
            digits = 2'd0;
          end
          default: abort(jsu_pkg::KIND_BAD_ESC);
        endcase
      end
      jsu_pkg::MODE_HEX1, jsu_pkg::MODE_HEX2: begin
        nib = 5'd0;
        if (b >= jsu_pkg::CH_0 && b <= jsu_pkg::CH_9) nib = {1'b1, b[3:0]};
        else if ((b >= jsu_pkg::CH_UA && b <= jsu_pkg::CH_UF) ||
                 (b >= jsu_pkg::CH_LA && b <= jsu_pkg::CH_LF))
          nib = {1'b1, b[3:0] + 4'd9};
        if (!nib[4]) begin
          abort(jsu_pkg::KIND_BAD_HEX);
        end else begin
          word = {unit_acc[11:0], nib[3:0]};
          unit_acc = word;
          if (digits != 2'd3) begin
            digits = digits + 2'd1;
          end else begin
            digits = 2'd0;
            if (mode == jsu_pkg::MODE_HEX1) begin
              // hold a high surrogate until its partner arrives
              if (word[15:10] == jsu_pkg::SURR_HI_TAG) begin
                high_bits = word[9:0];
                mode = jsu_pkg::MODE_WANT_BS;
              end else begin
                mode = jsu_pkg::MODE_BODY;
                add_utf8({5'd0, word});
              end
            end else if (word[15:10] != jsu_pkg::SURR_LO_TAG) begin
              abort(jsu_pkg::KIND_BAD_SURR);
            end else begin
              mode = jsu_pkg::MODE_BODY;
              add_utf8({1'b0, high_bits, word[9:0]} + jsu_pkg::SUPP_BASE);
            end
          end
        end
      end
      jsu_pkg::MODE_WANT_BS: begin
        if (b == jsu_pkg::CH_BSLASH) mode = jsu_pkg::MODE_WANT_U;
        else abort(jsu_pkg::KIND_BAD_SURR);
      end
      jsu_pkg::MODE_WANT_U: begin
        if (b == jsu_pkg::CH_U) begin
          mode = jsu_pkg::MODE_HEX2;
          unit_acc = 16'd0;
          digits = 2'd0;
        end else begin
          abort(jsu_pkg::KIND_BAD_SURR);
        end
      end
      default: mode = jsu_pkg::MODE_IDLE;
    endcase
    if (step_beats.size() != 0) step_beats[step_beats.size() - 1].last = 1'b1;
    decoded = {decoded, step_beats};
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      mode = jsu_pkg::MODE_IDLE;
      unit_acc = 16'd0;
      digits = 2'd0;
      high_bits = 10'd0;
      char_count = 16'd0;
      decoded.delete();
    end else begin
      if (in_tvalid && in_tready) unescape_byte(in_tdata);
      if (out_tvalid && out_tready) begin
        if (decoded.size() == 0) begin
          $error("beat with nothing expected: kind %0d, byte 0x%02h, length %0d",
                 out_tuser, out_tdata[7:0], out_tdata[23:8]);
          fail_count++;
        end else begin
          want = decoded.pop_front();
          if (out_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_tuser);
            fail_count++;
          end
          if (out_tdata[7:0] !== want.data) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.data, out_tdata[7:0]);
            fail_count++;
          end
          if (out_tdata[23:8] !== want.length) begin
            $error("out_length: expected %0d, got %0d", want.length, out_tdata[23:8]);
            fail_count++;
          end
          if (out_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = decoded.size();
  end

endmodule

[test/tb_json_string_unescape.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for the JSON string unescaper: directed strings and random
// strings under back-pressure. Depends on jsu_pkg, json_string_unescape and the checker.
module tb_json_string_unescape;

  localparam int RANDOM_ITEMS   = 190;
  localparam int LONG_HOLD      = 80;
  localparam int PRESSURE_BYTES = 12;
  localparam int TAIL_WAIT      = 10;
  localparam logic [7:0] CH_Q = 8'h71;  // 'q', not an escape letter

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // in_byte[7:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;   // out_byte[7:0], out_length[23:8]
  logic [2:0]  out_tuser;   // kind[2:0]
  logic        out_tlast;
  int          fail_count;
  int          pending;

  bit src_idle = 1'b0;
  bit sink_idle = 1'b0;
  bit long_hold_req = 1'b0;
  int items_sent = 0;

  always #5 clk = ~clk;

  json_string_unescape dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  json_string_unescape_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending(pending)
  );

  // Call at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (src_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_plain();
    logic [7:0] b;
    b = 8'($urandom_range(jsu_pkg::CTRL_LIMIT, 8'hFF));
    if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSLASH) b = b ^ 8'h01;
    send_byte(b);
  endtask

  // Four hex digits, mixed case; a non-digit replaces digit bad_at and ends the unit.
  task automatic send_hex(input logic [15:0] v, input int bad_at);
    logic [3:0] nib;
    logic [7:0] junk;
    int i;
    for (i = 0; i < 4; i++) begin
      nib = v[15 - 4 * i -: 4];
      if (i == bad_at) begin
        case ($urandom_range(0, 3))
          0: junk = 8'($urandom_range(8'h00, 8'h2F));
          1: junk = 8'($urandom_range(8'h3A, 8'h40));
          2: junk = 8'($urandom_range(8'h47, 8'h60));
          default: junk = 8'($urandom_range(8'h67, 8'hFF));
        endcase
        send_byte(junk);
        return;
      end
      if (nib < 4'd10) send_byte(jsu_pkg::CH_0 + nib);
      else if ($urandom_range(0, 1) == 1) send_byte(jsu_pkg::CH_UA + nib - 8'd10);
      else send_byte(jsu_pkg::CH_LA + nib - 8'd10);
    end
  endtask

  task automatic send_code_point(input logic [20:0] cp);
    logic [19:0] off;
    if (cp >= jsu_pkg::SUPP_BASE) begin
      off = 20'(cp - jsu_pkg::SUPP_BASE);
      send_text("\\u");
      send_hex({jsu_pkg::SURR_HI_TAG, off[19:10]}, -1);
      send_text("\\u");
      send_hex({jsu_pkg::SURR_LO_TAG, off[9:0]}, -1);
    end else begin
      send_text("\\u");
      send_hex(cp[15:0], -1);
    end
  endtask

  function automatic logic [20:0] pick_code_point();
    logic [20:0] cp;
    case ($urandom_range(0, 5))
      0: cp = 21'($urandom_range(21'h0, 21'h7F));
      1: cp = 21'($urandom_range(21'h80, 21'h7FF));
      2: begin
        cp = 21'($urandom_range(21'h800, 21'hFFFF));
        if (cp[15:10] == jsu_pkg::SURR_HI_TAG) cp[10] = 1'b1;  // turn into a lone low half
      end
      3: cp = 21'($urandom_range(21'hDC00, 21'hDFFF));
      4: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
      default: begin
        case ($urandom_range(0, 6))
          0: cp = 21'h7F;
          1: cp = 21'h80;
          2: cp = 21'h7FF;
          3: cp = 21'h800;
          4: cp = 21'hFFFF;
          5: cp = 21'h10000;
          default: cp = 21'h10FFFF;
        endcase
      end
    endcase
    return cp;
  endfunction

  // Stop offering and wait until every predicted beat has come out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic random_string();
    logic [7:0]  b;
    logic [15:0] high;
    logic [15:0] w;
    int n;
    int i;
    // noise while idle
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom);
        if (b == jsu_pkg::CH_QUOTE) b = ~b;
        send_byte(b);
      end
    end
    send_byte(jsu_pkg::CH_QUOTE);
    n = $urandom_range(0, 6);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_plain();
        5, 6: begin
          send_byte(jsu_pkg::CH_BSLASH);
          case ($urandom_range(0, 7))
            0: send_byte(jsu_pkg::CH_QUOTE);
            1: send_byte(jsu_pkg::CH_BSLASH);
            2: send_byte(jsu_pkg::CH_SLASH);
            3: send_byte(jsu_pkg::CH_B);
            4: send_byte(jsu_pkg::CH_F);
            5: send_byte(jsu_pkg::CH_N);
            6: send_byte(jsu_pkg::CH_R);
            default: send_byte(jsu_pkg::CH_T);
          endcase
        end
        default: send_code_point(pick_code_point());
      endcase
    end
    if ($urandom_range(0, 2) != 0) begin
      send_byte(jsu_pkg::CH_QUOTE);
    end else begin
      high = {jsu_pkg::SURR_HI_TAG, 10'($urandom)};
      case ($urandom_range(0, 8))
        0: send_byte(8'($urandom_range(8'h01, 8'h1F)));
        1: send_byte(jsu_pkg::CH_NUL);
        2: begin
          send_byte(jsu_pkg::CH_BSLASH);
          send_byte(jsu_pkg::CH_NUL);
        end
        3: begin
          send_byte(jsu_pkg::CH_BSLASH);
          b = 8'($urandom_range(8'h01, 8'hFF));
          case (b)
            jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSLASH, jsu_pkg::CH_SLASH,
            jsu_pkg::CH_B, jsu_pkg::CH_F, jsu_pkg::CH_N, jsu_pkg::CH_R,
            jsu_pkg::CH_T, jsu_pkg::CH_U: b = CH_Q;
            default: ;
          endcase
          send_byte(b);
        end
        4: begin
          send_text("\\u");
          send_hex(16'($urandom), $urandom_range(0, 3));
        end
        5: begin
          // high half followed by anything but a backslash
          send_text("\\u");
          send_hex(high, -1);
          b = 8'($urandom);
          if (b == jsu_pkg::CH_BSLASH) b = jsu_pkg::CH_QUOTE;
          send_byte(b);
        end
        6: begin
          send_text("\\u");
          send_hex(high, -1);
          send_byte(jsu_pkg::CH_BSLASH);
          b = 8'($urandom);
          if (b == jsu_pkg::CH_U) b = jsu_pkg::CH_NUL;
          send_byte(b);
        end
        7: begin
          // second unit outside the low half range
          send_text("\\u");
          send_hex(high, -1);
          send_text("\\u");
          w = 16'($urandom);
          if (w[15:10] == jsu_pkg::SURR_LO_TAG) w[15] = 1'b0;
          send_hex(w, -1);
        end
        default: begin
          send_text("\\u");
          send_hex(high, -1);
          send_text("\\u");
          send_hex({jsu_pkg::SURR_LO_TAG, 10'($urandom)}, $urandom_range(0, 3));
        end
      endcase
    end
  endtask

  initial begin : sink
    int hold;
    hold = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_tready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 12);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    int k;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = 8'd0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    src_idle = 1'b1;
    sink_idle = 1'b1;
    send_byte(8'hFF);                 // no opening quote
    send_byte(jsu_pkg::CH_NUL);
    send_byte(jsu_pkg::CH_QUOTE);     // text ends inside the string
    send_byte(jsu_pkg::CH_NUL);
    send_byte(jsu_pkg::CH_QUOTE);     // control byte
    send_byte(8'h1F);
    send_byte(jsu_pkg::CH_QUOTE);     // top and bottom plain bytes, \u0000, close
    send_byte(8'hFF);
    send_byte(jsu_pkg::CTRL_LIMIT);
    send_text("\\u0000\"");
    send_text("\"\\");                // text ends after a backslash
    send_byte(jsu_pkg::CH_NUL);
    send_text("\"\\q");               // unknown escape
    send_text("\"\"");                // empty string
    drain();

    items_sent = 0;
    k = 0;
    while (items_sent < RANDOM_ITEMS) begin
      k++;
      if (k % 6 == 0) drain();
      if (k >= 5 && k <= 7) begin
        // keep offering while the receiver holds off
        src_idle = 1'b0;
        sink_idle = 1'b0;
        if (k == 5) begin
          long_hold_req = 1'b1;
          send_byte(jsu_pkg::CH_QUOTE);
          repeat (PRESSURE_BYTES) send_plain();
          send_byte(jsu_pkg::CH_QUOTE);
        end
      end else begin
        src_idle = ($urandom_range(0, 3) != 0);
        sink_idle = ($urandom_range(0, 3) != 0);
      end
      random_string();
    end
    drain();

    // a few strings at full speed
    src_idle = 1'b0;
    sink_idle = 1'b0;
    repeat (4) random_string();

    drain();
    repeat (TAIL_WAIT) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
